/* sv/lhbp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lhbp_pkg;

   localparam int HISTORY_BITS  = 17;
   localparam int PC_INDEX_BITS = 13;
   localparam int PC_WIDTH      = 32;
   localparam int CTR_BITS      = 2;

   // The counter memory is organized as rows of LANES counters each.
   localparam int LANE_BITS     = 4;
   localparam int LANES         = 1 << LANE_BITS;
   localparam int ROW_BITS      = LANES * CTR_BITS;
   localparam int ROW_ADDR_BITS = HISTORY_BITS - LANE_BITS;
   localparam int HIST_ENTRIES  = 1 << PC_INDEX_BITS;
   localparam int ROW_ENTRIES   = 1 << ROW_ADDR_BITS;
   localparam int CLEAR_BITS    = (PC_INDEX_BITS > ROW_ADDR_BITS) ? PC_INDEX_BITS
                                                                  : ROW_ADDR_BITS;

   localparam logic [HISTORY_BITS-1:0] HIST_RESET = HISTORY_BITS'(65535);
   localparam logic [CTR_BITS-1:0]     CTR_RESET  = 2'd2;
   localparam logic [CTR_BITS-1:0]     CTR_MAX    = 2'd3;
   localparam logic [CTR_BITS-1:0]     CTR_MIN    = 2'd0;
   localparam logic [ROW_BITS-1:0]     ROW_RESET  = {LANES{CTR_RESET}};

   typedef enum logic {
      CMD_PREDICT = 1'b0,
      CMD_UPDATE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CTR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic ready;
      logic capture;
      logic clear_en;
      logic ctr_rd;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_update;
      logic rsp_full;
   } dp_status_type;

endpackage

`default_nettype wire

/* sv/lhbp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface lhbp_req_if;
   import lhbp_pkg::*;

   logic                valid;
   logic                ready;
   logic                cmd;
   logic [PC_WIDTH-1:0] pc;
   logic                taken;

   modport source (output valid, output cmd, output pc, output taken, input ready);
   modport sink   (input valid, input cmd, input pc, input taken, output ready);
endinterface

interface lhbp_rsp_if;
   logic valid;
   logic ready;
   logic predict_taken;

   modport source (output valid, output predict_taken, input ready);
   modport sink   (input valid, input predict_taken, output ready);
endinterface

`default_nettype wire

/* sv/lhbp_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module lhbp_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire lhbp_pkg::dp_status_type status,
   output lhbp_pkg::ctl_cmd_type       cmd
);
   import lhbp_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CTR;
            end
         end
         ST_CTR: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.is_update || !status.rsp_full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
         end
         ST_IDLE: begin
            cmd.ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_CTR: begin
            cmd.ctr_rd = 1'b1;
         end
         ST_DONE: begin
            cmd.finish = status.is_update || !status.rsp_full;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

`ifndef SYNTH
   a_finish_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && !status.is_update) |-> !status.rsp_full)
      else $error("prediction finished while the response register was still full");

   a_clear_exits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && status.clear_last) |=> (state_ff == ST_IDLE))
      else $error("clearing pass did not end after its last entry");

   a_capture_reads_row: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.ctr_rd)
      else $error("accepted transaction was not followed by a counter row read");

   a_row_read_then_done: assert property (@(posedge clock) disable iff (reset)
      cmd.ctr_rd |=> (state_ff == ST_DONE))
      else $error("counter row read was not followed by the completion state");
`endif

endmodule

`default_nettype wire

/* sv/lhbp_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module lhbp_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire lhbp_pkg::ctl_cmd_type           cmd,
   input  wire logic                            req_cmd,
   input  wire logic [lhbp_pkg::PC_WIDTH-1:0]   req_pc,
   input  wire logic                            req_taken,
   input  wire logic                            rsp_ready,
   output lhbp_pkg::dp_status_type              status,
   output logic                                 rsp_valid,
   output logic                                 rsp_predict_taken
);
   import lhbp_pkg::*;

   // History and counter storage.
   logic [HISTORY_BITS-1:0] hist_mem [HIST_ENTRIES];
   logic [ROW_BITS-1:0]     ctr_mem  [ROW_ENTRIES];

   logic [CLEAR_BITS-1:0]    clear_cnt_ff;
   logic [PC_INDEX_BITS-1:0] slot_ff;
   logic                     cmd_ff;
   logic                     taken_ff;
   logic [HISTORY_BITS-1:0]  hist_rd_ff;
   logic [ROW_BITS-1:0]      row_rd_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_taken_ff;

   logic [LANE_BITS-1:0]    lane;
   logic [CTR_BITS-1:0]     ctr_cur;
   logic [CTR_BITS-1:0]     ctr_new;
   logic [ROW_BITS-1:0]     row_new;
   logic [HISTORY_BITS-1:0] hist_new;
   logic                    is_update;
   logic                    commit_update;
   logic                    commit_predict;

   assign is_update      = (cmd_ff == CMD_UPDATE);
   assign commit_update  = cmd.finish && is_update;
   assign commit_predict = cmd.finish && !is_update;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else if (cmd.clear_en) begin
         clear_cnt_ff <= clear_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         slot_ff  <= req_pc[PC_INDEX_BITS-1:0];
         cmd_ff   <= req_cmd;
         taken_ff <= req_taken;
      end
   end

   // History memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         hist_mem[clear_cnt_ff[PC_INDEX_BITS-1:0]] <= HIST_RESET;
      end else if (commit_update) begin
         hist_mem[slot_ff] <= hist_new;
      end
      if (cmd.capture) begin
         hist_rd_ff <= hist_mem[req_pc[PC_INDEX_BITS-1:0]];
      end
   end

   // Counter memory: rows of counters, read-modify-write on update.
   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         ctr_mem[clear_cnt_ff[ROW_ADDR_BITS-1:0]] <= ROW_RESET;
      end else if (commit_update) begin
         ctr_mem[hist_rd_ff[HISTORY_BITS-1:LANE_BITS]] <= row_new;
      end
      if (cmd.ctr_rd) begin
         row_rd_ff <= ctr_mem[hist_rd_ff[HISTORY_BITS-1:LANE_BITS]];
      end
   end

   always_comb begin
      lane    = hist_rd_ff[LANE_BITS-1:0];
      ctr_cur = row_rd_ff[lane*CTR_BITS +: CTR_BITS];
      if (taken_ff) begin
         ctr_new = (ctr_cur == CTR_MAX) ? ctr_cur : CTR_BITS'(ctr_cur + 1'b1);
      end else begin
         ctr_new = (ctr_cur == CTR_MIN) ? ctr_cur : CTR_BITS'(ctr_cur - 1'b1);
      end
      row_new = row_rd_ff;
      row_new[lane*CTR_BITS +: CTR_BITS] = ctr_new;
      hist_new = {hist_rd_ff[HISTORY_BITS-2:0], taken_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit_predict) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit_predict) begin
         rsp_taken_ff <= ctr_cur[CTR_BITS-1];
      end
   end

   assign status.clear_last = (clear_cnt_ff == {CLEAR_BITS{1'b1}});
   assign status.is_update  = is_update;
   assign status.rsp_full   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_predict_taken = rsp_taken_ff;

endmodule

`default_nettype wire

/* sv/local_history_branch_predictor_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload                         Handshake
// req_bus   in         cmd, pc[31:0], taken            valid / ready
// rsp_bus   out        predict_taken                   valid / ready
//
// A transaction steps through the states ST_IDLE, where it is accepted and the history entry
// is read, ST_CTR, which reads the counter row, and ST_DONE, which writes back the counter
// row and history (update) or loads the response register (predict). A new transaction is
// accepted only once the previous one has returned to ST_IDLE. After reset a clearing pass
// writes every history entry and counter row; no transaction is accepted until it finishes.
// A prediction waits in its final cycle while the previous response is still held by the
// sink; updates never wait.

module local_history_branch_predictor_core (
   input wire logic   clock,
   input wire logic   reset,
   lhbp_req_if.sink   req_bus,
   lhbp_rsp_if.source rsp_bus
);
   import lhbp_pkg::*;

   ctl_cmd_type   ctl_cmd;
   dp_status_type dp_status;

   // The controller sequences each transaction and the clearing pass.
   lhbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .status    (dp_status),
      .cmd       (ctl_cmd)
   );

   // The datapath holds both tables, the captured request and the response register.
   lhbp_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (ctl_cmd),
      .req_cmd           (req_bus.cmd),
      .req_pc            (req_bus.pc),
      .req_taken         (req_bus.taken),
      .rsp_ready         (rsp_bus.ready),
      .status            (dp_status),
      .rsp_valid         (rsp_bus.valid),
      .rsp_predict_taken (rsp_bus.predict_taken)
   );

   // The request side is ready whenever the controller is idle; a pending response
   // does not block acceptance.
   assign req_bus.ready = ctl_cmd.ready;

endmodule

`default_nettype wire
